>>> src/adsbp_pkg.sv
// Shared types and constants for the advertising service data beacon parser.
package adsbp_pkg;

    localparam int ID_BYTES     = 16;
    localparam int CAP_IDX_W    = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
    localparam int OUT_ID_BYTES = 16;
    localparam int IDS_W        = OUT_ID_BYTES * 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [7:0]  TARGET_TYPE_RST = 8'h2a;
    localparam logic [15:0] TARGET_UUID_RST = 16'h2af5;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FIELD_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_UUID       = 2'd1;

    localparam logic [1:0] KIND_BEACON  = 2'd0;
    localparam logic [1:0] KIND_END_OK  = 2'd1;
    localparam logic [1:0] KIND_END_BAD = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDS_W-1:0] ids;
        logic             last;
    } result_t;

endpackage

>>> src/adv_service_data_beacon_parser.sv
// Top level: byte-wise LTV walker that reports service data beacons and packet status.
// A result is registered on the master side and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the master side accepts results; a byte that yields a beacon
// and a status puts the second result in a pending register that holds off new bytes.
// Reset: asynchronous, active low; clears parse state and output valids, and restores
// the target type 0x2a and UUID 0x2af5. The capture store is not cleared.
module adv_service_data_beacon_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [adsbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adsbp_pkg::CFG_DATA_W-1:0]  cfg_data,
    // byte stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
    input  logic                              s_axis_tlast,   // end_of_packet
    // result stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [adsbp_pkg::IDS_W-1:0]       m_axis_tdata,   // org_id, student_id head, tail
    output logic [1:0]                        m_axis_tuser,   // result_kind
    output logic                              m_axis_tlast    // last
);
    import adsbp_pkg::*;

    logic [7:0]  target_type_reg;
    logic [15:0] target_uuid_reg;

    logic [7:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] ftype_reg, ftype_next;
    logic       matched_reg, matched_next;
    logic       bad_reg, bad_next;

    logic [7:0] cap_mem [ID_BYTES];

    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    result_t pend_reg, pend_next;
    logic    pend_valid_reg, pend_valid_next;

    logic                 in_acc;
    logic                 out_take;
    logic [7:0]           b;
    logic                 eop;
    logic [7:0]           d;
    logic [7:0]           dc;
    logic                 cap_we;
    logic [CAP_IDX_W-1:0] cap_idx;
    logic                 beacon;
    logic                 bad_now;
    logic [7:0]           id_byte [OUT_ID_BYTES];
    logic [IDS_W-1:0]     ids;
    result_t              r_beacon, r_status;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !pend_valid_reg && (!out_valid_reg || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_take      = out_valid_reg && m_axis_tready;
    assign b             = s_axis_tdata;
    assign eop           = s_axis_tlast;
    assign d             = pos_reg - 8'd2;
    assign dc            = d - 8'd2;
    assign cap_idx       = dc[CAP_IDX_W-1:0];

    always_comb
    begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        ftype_next   = ftype_reg;
        matched_next = matched_reg;
        bad_next     = bad_reg;
        cap_we       = 1'b0;
        beacon       = 1'b0;
        if (!bad_reg)
        begin
            if (pos_reg == 8'd0)
            begin
                if (b == 8'd0)
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    len_next = b;
                    pos_next = 8'd1;
                end
            end
            else if (pos_reg == 8'd1)
            begin
                ftype_next   = b;
                matched_next = 1'b0;
                pos_next     = (len_reg == 8'd1) ? 8'd0 : 8'd2;
            end
            else
            begin
                if (d == 8'd0)
                begin
                    matched_next = (ftype_reg == target_type_reg) && (b == target_uuid_reg[7:0]);
                end
                else if (d == 8'd1)
                begin
                    matched_next = matched_reg && (b == target_uuid_reg[15:8]);
                end
                else if (matched_reg && ({1'b0, dc} < 9'(ID_BYTES)))
                begin
                    cap_we = 1'b1;
                    if (({1'b0, dc} == 9'(ID_BYTES - 1)) &&
                        ({1'b0, len_reg} >= 9'(ID_BYTES + 3)))
                    begin
                        beacon = 1'b1;
                    end
                end
                if (pos_reg >= len_reg)
                begin
                    pos_next = 8'd0;
                end
                else
                begin
                    pos_next = pos_reg + 8'd1;
                end
            end
        end
        bad_now = bad_next;
        if (eop)
        begin
            pos_next     = 8'd0;
            len_next     = 8'd0;
            ftype_next   = 8'd0;
            matched_next = 1'b0;
            bad_next     = 1'b0;
        end
    end

    // last captured byte is the one arriving now
    always_comb
    begin
        for (int k = 0; k < OUT_ID_BYTES; k++)
        begin
            if (k < ID_BYTES - 1)
            begin
                id_byte[k] = cap_mem[k];
            end
            else if (k == ID_BYTES - 1)
            begin
                id_byte[k] = b;
            end
            else
            begin
                id_byte[k] = 8'd0;
            end
        end
    end

    assign ids = {id_byte[14], id_byte[15],
                  id_byte[6], id_byte[7], id_byte[8], id_byte[9],
                  id_byte[10], id_byte[11], id_byte[12], id_byte[13],
                  id_byte[0], id_byte[1], id_byte[2], id_byte[3], id_byte[4], id_byte[5]};

    always_comb
    begin
        r_beacon.kind = KIND_BEACON;
        r_beacon.ids  = ids;
        r_beacon.last = !eop;
        r_status.kind = bad_now ? KIND_END_BAD : KIND_END_OK;
        r_status.ids  = '0;
        r_status.last = 1'b1;
    end

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (in_acc && (beacon || eop))
        begin
            out_next        = beacon ? r_beacon : r_status;
            out_valid_next  = 1'b1;
            pend_next       = r_status;
            pend_valid_next = beacon && eop;
        end
        else if (out_take)
        begin
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_type_reg <= TARGET_TYPE_RST;
            target_uuid_reg <= TARGET_UUID_RST;
            pos_reg         <= 8'd0;
            len_reg         <= 8'd0;
            ftype_reg       <= 8'd0;
            matched_reg     <= 1'b0;
            bad_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_TARGET_FIELD_TYPE: target_type_reg <= cfg_data[7:0];
                    REG_TARGET_UUID:       target_uuid_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_acc)
            begin
                pos_reg     <= pos_next;
                len_reg     <= len_next;
                ftype_reg   <= ftype_next;
                matched_reg <= matched_next;
                bad_reg     <= bad_next;
            end
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
        if (in_acc && cap_we)
        begin
            cap_mem[cap_idx] <= b;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.ids;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

`ifndef SYNTHESIS
    a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (m_axis_tvalid && !s_axis_tready))
        else $error("pending result without a held output");

    a_beacon_then_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_BEACON && !m_axis_tlast) |-> pend_valid_reg)
        else $error("beacon marked not last without a queued status");

    a_status_zero_ids: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_BEACON) |-> (m_axis_tdata == '0 && m_axis_tlast))
        else $error("status result carries id bytes");

    a_bad_clears_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tlast) |=> (!bad_reg && pos_reg == 8'd0))
        else $error("parse state not cleared at end of packet");
`endif

endmodule
